/* sv/cpio_newc_archive_validator_assert.svh */
// Assertion helpers used by the validator's result queue module.
// They expect a clock named aclk and an active-low reset named aresetn.
`ifndef CPIO_NEWC_ARCHIVE_VALIDATOR_ASSERT_SVH
`define CPIO_NEWC_ARCHIVE_VALIDATOR_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define CPIO_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("cpio validator check failed");

// Condition that must hold in the cycle after a trigger
`define CPIO_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("cpio validator sequence check failed");

`endif

/* sv/cpio_pkg.sv */
`timescale 1ns / 1ps
package cpio_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_NAME    = 3'd1,
        PH_NAMEPAD = 3'd2,
        PH_DATA    = 3'd3,
        PH_TAILPAD = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNC     = 3'd1;
    localparam logic [2:0] ST_MAGIC     = 3'd2;
    localparam logic [2:0] ST_HEX       = 3'd3;
    localparam logic [2:0] ST_NAME      = 3'd4;
    localparam logic [2:0] ST_BOUNDS    = 3'd5;
    localparam logic [2:0] ST_TYPE      = 3'd6;
    localparam logic [2:0] ST_NOTRAILER = 3'd7;

    localparam logic [6:0]  HDR_BYTES     = 7'd110;
    localparam logic [6:0]  MAGIC_BYTES   = 7'd6;
    localparam logic [12:0] NAME_CAP      = 13'd4096;
    localparam logic [12:0] LIMIT_RESET   = 13'd256;
    localparam logic [31:0] TRAILER_NSIZE = 32'd11;
    localparam logic [31:0] MODE_FMT_MASK = 32'h0000_F000;
    localparam logic [31:0] MODE_REG      = 32'h0000_8000;
    localparam logic [31:0] MODE_DIR      = 32'h0000_4000;
    localparam logic [11:0] TRAILER_LEN   = 12'd10;
    localparam logic [11:0] NIDX_MAX      = 12'd4095;

    typedef struct packed {
        logic        is_final;
        logic [2:0]  status_code;
        logic [31:0] entries_seen;
        logic [31:0] failing_offset;
        logic [31:0] entry_mode;
        logic [31:0] entry_size;
        logic [11:0] entry_name_length;
        logic [31:0] entry_data_offset;
    } result_t;

    // Results of one accepted byte: zero, one or two
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [7:0] magic_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = 8'h30;
            3'd1:    c = 8'h37;
            3'd2:    c = 8'h30;
            3'd3:    c = 8'h37;
            3'd4:    c = 8'h30;
            3'd5:    c = 8'h31;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] i);
        logic [7:0] c;
        unique case (i)
            4'd0:    c = 8'h54;
            4'd1:    c = 8'h52;
            4'd2:    c = 8'h41;
            4'd3:    c = 8'h49;
            4'd4:    c = 8'h4C;
            4'd5:    c = 8'h45;
            4'd6:    c = 8'h52;
            4'd7:    c = 8'h21;
            4'd8:    c = 8'h21;
            4'd9:    c = 8'h21;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Bit 4 set marks a byte that is no hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h37);
        end else begin
            d = 5'd16;
        end
        return d;
    endfunction

endpackage

/* sv/cpio_parser.sv */
`timescale 1ns / 1ps
module cpio_parser #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic                cfg_we,
    input  logic [12:0]         cfg_wdata,
    output cpio_pkg::push_t     push
);

    localparam int WX = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

    cpio_pkg::phase_t       phase_reg, phase_next;
    logic [6:0]             hbi_reg, hbi_next;
    logic [31:0]            acc_reg, acc_next;
    logic [31:0]            mode_reg, mode_next;
    logic [31:0]            fsize_reg, fsize_next;
    logic [31:0]            nsize_reg, nsize_next;
    logic [2:0]             perr_reg, perr_next;
    logic [11:0]            nidx_reg, nidx_next;
    logic                   trl_reg, trl_next;
    logic [OFFSET_BITS-1:0] ofs_reg, ofs_next;
    logic [OFFSET_BITS-1:0] estart_reg, estart_next;
    logic [31:0]            rem_reg, rem_next;
    logic [31:0]            cnt_reg, cnt_next;
    logic [12:0]            limit_reg;

    logic [OFFSET_BITS-1:0] endo;
    logic [OFFSET_BITS-1:0] doff;
    logic [12:0]            lim;
    logic [4:0]             dig;
    logic [6:0]             rel;
    logic [6:0]             hi1;
    logic [1:0]             pad;
    logic [31:0]            mtype;
    logic                   do_entry;
    logic                   final_done;
    cpio_pkg::push_t        res;

    function automatic logic [31:0] lo32(input logic [OFFSET_BITS-1:0] v);
        logic [WX-1:0] x;
        x = WX'(v);
        return x[31:0];
    endfunction

    function automatic cpio_pkg::push_t add_res(input cpio_pkg::push_t p,
                                                input cpio_pkg::result_t r);
        cpio_pkg::push_t q;
        q = p;
        if (p.n == 2'd0) begin
            q.r0 = r;
        end else begin
            q.r1 = r;
        end
        q.n = p.n + 2'd1;
        return q;
    endfunction

    function automatic cpio_pkg::result_t fin_res(input logic [2:0] st,
                                                  input logic [31:0] cnt,
                                                  input logic [31:0] fo);
        cpio_pkg::result_t r;
        r = '0;
        r.is_final       = 1'b1;
        r.status_code    = st;
        r.entries_seen   = cnt;
        r.failing_offset = fo;
        return r;
    endfunction

    // Process one byte
    always_comb begin
        phase_next  = phase_reg;
        hbi_next    = hbi_reg;
        acc_next    = acc_reg;
        mode_next   = mode_reg;
        fsize_next  = fsize_reg;
        nsize_next  = nsize_reg;
        perr_next   = perr_reg;
        nidx_next   = nidx_reg;
        trl_next    = trl_reg;
        ofs_next    = ofs_reg;
        estart_next = estart_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        res         = '0;
        do_entry    = 1'b0;
        final_done  = 1'b0;
        dig         = 5'd0;
        rel         = 7'd0;
        hi1         = 7'd0;
        pad         = 2'd0;
        mtype       = 32'd0;
        doff        = '0;
        endo        = ofs_reg + OFFSET_BITS'(1);
        lim         = (limit_reg > cpio_pkg::NAME_CAP) ? cpio_pkg::NAME_CAP : limit_reg;

        unique case (phase_reg)
            cpio_pkg::PH_HEADER: begin
                if (hbi_reg == 7'd0) begin
                    estart_next = ofs_reg;
                    perr_next   = cpio_pkg::ST_OK;
                    acc_next    = 32'd0;
                end
                if (hbi_reg < cpio_pkg::MAGIC_BYTES) begin
                    if (data_byte != cpio_pkg::magic_char(hbi_reg[2:0])
                        && perr_next == cpio_pkg::ST_OK) begin
                        perr_next = cpio_pkg::ST_MAGIC;
                    end
                end else begin
                    dig = cpio_pkg::hex_digit(data_byte);
                    if (dig[4] && perr_next == cpio_pkg::ST_OK) begin
                        perr_next = cpio_pkg::ST_HEX;
                    end
                    acc_next = {acc_next[27:0], dig[3:0]};
                    rel = hbi_reg - cpio_pkg::MAGIC_BYTES;
                    if (rel[2:0] == 3'd7) begin
                        case (rel[6:3])
                            4'd1:    mode_next  = acc_next;
                            4'd6:    fsize_next = acc_next;
                            4'd11:   nsize_next = acc_next;
                            default: ;
                        endcase
                    end
                end
                hi1 = hbi_reg + 7'd1;
                if (hi1 >= cpio_pkg::HDR_BYTES) begin
                    hbi_next = 7'd0;
                    if (perr_next != cpio_pkg::ST_OK) begin
                        res = add_res(res, fin_res(perr_next, cnt_next, lo32(estart_next)));
                        phase_next = cpio_pkg::PH_DONE;
                        final_done = 1'b1;
                    end else if (nsize_next < 32'd2 || nsize_next > {19'd0, lim}) begin
                        res = add_res(res, fin_res(cpio_pkg::ST_NAME, cnt_next,
                                                   lo32(estart_next)));
                        phase_next = cpio_pkg::PH_DONE;
                        final_done = 1'b1;
                    end else begin
                        phase_next = cpio_pkg::PH_NAME;
                        nidx_next  = 12'd0;
                        rem_next   = nsize_next;
                        trl_next   = 1'b1;
                        perr_next  = cpio_pkg::ST_OK;
                    end
                end else begin
                    hbi_next = hi1;
                end
            end
            cpio_pkg::PH_NAME: begin
                if (nidx_reg == 12'd0 && data_byte == 8'h2F) begin
                    perr_next = cpio_pkg::ST_NAME;
                end
                if ({20'd0, nidx_reg} < nsize_reg - 32'd1 && data_byte == 8'h00) begin
                    perr_next = cpio_pkg::ST_NAME;
                end
                if ({20'd0, nidx_reg} == nsize_reg - 32'd1 && data_byte != 8'h00) begin
                    perr_next = cpio_pkg::ST_NAME;
                end
                if (nidx_reg < cpio_pkg::TRAILER_LEN) begin
                    if (data_byte != cpio_pkg::trailer_char(nidx_reg[3:0])) begin
                        trl_next = 1'b0;
                    end
                end
                if (nidx_reg < cpio_pkg::NIDX_MAX) begin
                    nidx_next = nidx_reg + 12'd1;
                end
                rem_next = rem_reg - 32'd1;
                if (rem_next == 32'd0) begin
                    if (perr_next != cpio_pkg::ST_OK) begin
                        res = add_res(res, fin_res(cpio_pkg::ST_NAME, cnt_next,
                                                   lo32(estart_reg)));
                        phase_next = cpio_pkg::PH_DONE;
                        final_done = 1'b1;
                    end else begin
                        pad = 2'd0 - endo[1:0];
                        if (pad != 2'd0) begin
                            phase_next = cpio_pkg::PH_NAMEPAD;
                            rem_next   = {30'd0, pad};
                        end else if (fsize_reg == 32'd0) begin
                            do_entry = 1'b1;
                        end else begin
                            phase_next = cpio_pkg::PH_DATA;
                            rem_next   = fsize_reg;
                        end
                    end
                end
            end
            cpio_pkg::PH_NAMEPAD: begin
                rem_next = rem_reg - 32'd1;
                if (rem_next == 32'd0) begin
                    if (fsize_reg == 32'd0) begin
                        do_entry = 1'b1;
                    end else begin
                        phase_next = cpio_pkg::PH_DATA;
                        rem_next   = fsize_reg;
                    end
                end
            end
            cpio_pkg::PH_DATA: begin
                rem_next = rem_reg - 32'd1;
                if (rem_next == 32'd0) begin
                    do_entry = 1'b1;
                end
            end
            cpio_pkg::PH_TAILPAD: begin
                rem_next = rem_reg - 32'd1;
                if (rem_next == 32'd0) begin
                    phase_next = cpio_pkg::PH_HEADER;
                    hbi_next   = 7'd0;
                end
            end
            default: begin
                phase_next = cpio_pkg::PH_DONE;
            end
        endcase

        // Close the entry once its data has arrived
        if (do_entry) begin
            mtype = mode_reg & cpio_pkg::MODE_FMT_MASK;
            if (trl_next && nsize_reg == cpio_pkg::TRAILER_NSIZE) begin
                res = add_res(res, fin_res(cpio_pkg::ST_OK, cnt_next, 32'd0));
                phase_next = cpio_pkg::PH_DONE;
                final_done = 1'b1;
            end else if (mtype != cpio_pkg::MODE_REG && mtype != cpio_pkg::MODE_DIR) begin
                res = add_res(res, fin_res(cpio_pkg::ST_TYPE, cnt_next, lo32(estart_reg)));
                phase_next = cpio_pkg::PH_DONE;
                final_done = 1'b1;
            end else begin
                if (cnt_next != 32'hFFFF_FFFF) begin
                    cnt_next = cnt_next + 32'd1;
                end
                doff = endo - OFFSET_BITS'(fsize_reg);
                res = add_res(res, '{is_final: 1'b0, status_code: cpio_pkg::ST_OK,
                                     entries_seen: cnt_next, failing_offset: 32'd0,
                                     entry_mode: mode_reg, entry_size: fsize_reg,
                                     entry_name_length: 12'(nsize_reg - 32'd1),
                                     entry_data_offset: lo32(doff)});
                pad = 2'd0 - endo[1:0];
                if (pad != 2'd0) begin
                    phase_next = cpio_pkg::PH_TAILPAD;
                    rem_next   = {30'd0, pad};
                end else begin
                    phase_next = cpio_pkg::PH_HEADER;
                    hbi_next   = 7'd0;
                end
            end
        end

        // End of stream: report and return to the reset state
        if (last_byte) begin
            if (!final_done && phase_next != cpio_pkg::PH_DONE) begin
                case (phase_next) inside
                    cpio_pkg::PH_HEADER: begin
                        if (hbi_next == 7'd0) begin
                            res = add_res(res, fin_res(cpio_pkg::ST_NOTRAILER, cnt_next,
                                                       lo32(endo)));
                        end else begin
                            res = add_res(res, fin_res(cpio_pkg::ST_TRUNC, cnt_next,
                                                       lo32(estart_next)));
                        end
                    end
                    cpio_pkg::PH_NAME: begin
                        res = add_res(res, fin_res(cpio_pkg::ST_TRUNC, cnt_next,
                                                   lo32(estart_next)));
                    end
                    cpio_pkg::PH_NAMEPAD, cpio_pkg::PH_DATA: begin
                        res = add_res(res, fin_res(cpio_pkg::ST_BOUNDS, cnt_next,
                                                   lo32(estart_next)));
                    end
                    default: begin
                        res = add_res(res, fin_res(cpio_pkg::ST_NOTRAILER, cnt_next,
                                      lo32(endo + OFFSET_BITS'(rem_next))));
                    end
                endcase
            end
            phase_next  = cpio_pkg::PH_HEADER;
            hbi_next    = 7'd0;
            acc_next    = 32'd0;
            mode_next   = 32'd0;
            fsize_next  = 32'd0;
            nsize_next  = 32'd0;
            perr_next   = cpio_pkg::ST_OK;
            nidx_next   = 12'd0;
            trl_next    = 1'b1;
            ofs_next    = '0;
            estart_next = '0;
            rem_next    = 32'd0;
            cnt_next    = 32'd0;
        end else begin
            ofs_next = endo;
        end
    end

    // Drop the results of cycles without a request
    always_comb begin
        push = res;
        if (!in_accept) begin
            push.n = 2'd0;
        end
    end

    // Hold the limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= cpio_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // Advance the parse state on each request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= cpio_pkg::PH_HEADER;
            hbi_reg    <= 7'd0;
            acc_reg    <= 32'd0;
            mode_reg   <= 32'd0;
            fsize_reg  <= 32'd0;
            nsize_reg  <= 32'd0;
            perr_reg   <= cpio_pkg::ST_OK;
            nidx_reg   <= 12'd0;
            trl_reg    <= 1'b1;
            ofs_reg    <= '0;
            estart_reg <= '0;
            rem_reg    <= 32'd0;
            cnt_reg    <= 32'd0;
        end else if (in_accept) begin
            phase_reg  <= phase_next;
            hbi_reg    <= hbi_next;
            acc_reg    <= acc_next;
            mode_reg   <= mode_next;
            fsize_reg  <= fsize_next;
            nsize_reg  <= nsize_next;
            perr_reg   <= perr_next;
            nidx_reg   <= nidx_next;
            trl_reg    <= trl_next;
            ofs_reg    <= ofs_next;
            estart_reg <= estart_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* sv/cpio_result_fifo.sv */
`timescale 1ns / 1ps
`include "cpio_newc_archive_validator_assert.svh"
module cpio_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  cpio_pkg::push_t   push,
    input  logic              pop,
    output logic              room2,
    output logic              out_valid,
    output cpio_pkg::result_t out_data
);

    cpio_pkg::result_t mem [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = mem[rp_reg];
    assign room2     = (cnt_reg <= 3'd2);
    assign do_pop    = pop && out_valid;

    // Advance pointers and occupancy
    always_comb begin
        wp_next  = wp_reg + push.n;
        rp_next  = rp_reg + {1'b0, do_pop};
        cnt_next = cnt_reg + {1'b0, push.n} - {2'd0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store up to two results per cycle
    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wp_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem[wp_reg + 2'd1] <= push.r1;
        end
    end

    `CPIO_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= 3'd4)
    `CPIO_ASSERT_NEXT(a_pop_only, (do_pop && push.n == 2'd0), cnt_reg == $past(cnt_reg) - 3'd1)
    `CPIO_ASSERT_NEXT(a_push_two, (!do_pop && push.n == 2'd2), cnt_reg == $past(cnt_reg) + 3'd2)

endmodule

/* sv/cpio_newc_archive_validator.sv */
// Results of an accepted byte are registered in the result queue and offered on the master side in order.
// Throughput: one archive byte per cycle while s_tready is high; the byte update is a single registered pass.
// A byte may raise two results; s_tready drops while the 4-deep result queue holds 3 or more.
// Reset: aresetn is synchronous and active low; it clears the parse state and the queue
// and sets the name size limit to 256.
`timescale 1ns / 1ps
module cpio_newc_archive_validator #(
    parameter int OFFSET_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // status_code[2:0], entries_seen[34:3], failing_offset[66:35], entry_mode[98:67],
    // entry_size[130:99], entry_name_length[142:131], entry_data_offset[174:143], zero[175]
    output logic [175:0] m_tdata,
    output logic         m_tuser,   // is_final
    input  logic         cfg_we,
    input  logic [12:0]  cfg_wdata
);

    cpio_pkg::push_t   push;
    cpio_pkg::result_t head;
    logic              room2;
    logic              in_accept;

    assign s_tready  = room2;
    assign in_accept = s_tvalid && room2;

    cpio_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push)
    );

    cpio_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_tready),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_data  (head)
    );

    // Pack the head result
    assign m_tuser = head.is_final;
    assign m_tdata = {1'b0, head.entry_data_offset, head.entry_name_length, head.entry_size,
                      head.entry_mode, head.failing_offset, head.entries_seen,
                      head.status_code};

endmodule
